/* design/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define CFOL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define CFOL_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cfol_pkg.sv */
package cfol_pkg;

  localparam int STAGE_SLOTS_DEF = 8;

  localparam int SAMPLE_W = 24;
  localparam int HIST_W   = 32;
  localparam int GAIN_W   = 24;
  localparam int COEF_A_W = 32;
  localparam int COEF_B_W = 31;
  localparam int ORDER_W  = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [GAIN_W-1:0]   GAIN_RST   = 24'd65536;
  localparam logic [COEF_A_W-1:0] COEF_A_RST = '0;
  localparam logic [COEF_B_W-1:0] COEF_B_RST = '0;
  localparam logic [ORDER_W-1:0]  ORDER_RST  = 3'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN     = 2'd0,
    REG_COEF_FB  = 2'd1,
    REG_COEF_IN  = 2'd2,
    REG_STAGES   = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_MUL,
    ST_SCALE_RND,
    ST_STG_MUL,
    ST_STG_ADD,
    ST_FINISH
  } state_t;

  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [35:0] v);
    logic signed [35:0] hi;
    logic signed [35:0] lo;
    hi = 36'sd2147483647;
    lo = -36'sd2147483648;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[HIST_W-1:0];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [HIST_W-1:0] v);
    if (v > 32'sd8388607) return 24'h7F_FFFF;
    if (v < -32'sd8388608) return 24'h80_0000;
    return v[SAMPLE_W-1:0];
  endfunction

endpackage

/* design/cascaded_first_order_lowpass.sv */
// Cascaded first-order lowpass: each transfer on in_ carries one Q1.23 sample
// (restart flag in in_tuser clears all stage history first); the sample is
// scaled by the Q8.16 gain and run through stages_in_use (0..STAGE_SLOTS-1)
// bilinear stages, and one saturated Q1.23 sample leaves on out_. Items are
// processed one at a time: in_tready stays low from an item's transfer until
// its result is loaded into the output register, so no new sample is taken
// before the last one is through. The pace is set by the single shared
// multiply pair, which handles one stage at a time, and by the stage history
// memory with one read and one write port. A result waiting on out_ stalls
// only the final write-back of the next item. The user must write
// coefficients and order over cfg_ only while the block is idle; the block
// itself does not enforce this.
`include "assert_macros.svh"

module cascaded_first_order_lowpass #(
  parameter int STAGE_SLOTS = cfol_pkg::STAGE_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cfol_pkg::SAMPLE_W-1:0]     in_tdata,   // [23:0] sample_in
  input  logic                              in_tuser,   // [0] restart
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cfol_pkg::SAMPLE_W-1:0]     out_tdata,  // [23:0] sample_out
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cfol_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cfol_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int IDX_W = $clog2(STAGE_SLOTS);
  localparam int HW    = cfol_pkg::HIST_W;

  cfol_pkg::state_t state_r, state_nxt;

  logic [cfol_pkg::GAIN_W-1:0]          gain_r;
  logic signed [cfol_pkg::COEF_A_W-1:0] coef_fb_r;
  logic [cfol_pkg::COEF_B_W-1:0]        coef_in_r;
  logic [cfol_pkg::ORDER_W-1:0]         stages_r;

  logic [HW-1:0]          mem_r [STAGE_SLOTS];
  logic [STAGE_SLOTS-1:0] vld_r;
  logic [HW-1:0]          rd_data_r;
  logic                   rd_vld_r;

  logic                   rd_en;
  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [HW-1:0]          wr_data;
  logic                   load_out;
  logic                   out_free;
  logic                   in_xfer;

  logic signed [cfol_pkg::SAMPLE_W-1:0] sample_r;
  logic [IDX_W-1:0]       order_r, order_nxt;
  logic [IDX_W-1:0]       idx_r;
  logic signed [48:0]     prod_r;
  logic signed [HW-1:0]   cur_r;
  logic signed [HW-1:0]   prev_r;
  logic signed [63:0]     p1_r;
  logic signed [64:0]     p2_r;

  logic signed [HW-1:0]   hist_q;
  logic signed [48:0]     sc_sh;
  logic signed [63:0]     p1_sh;
  logic signed [64:0]     p2_sh;
  logic signed [35:0]     acc;
  logic signed [32:0]     sum_s;
  logic signed [HW-1:0]   coef_in_s;

  logic                   out_valid_r;
  logic [cfol_pkg::SAMPLE_W-1:0] out_data_r;

  assign cfg_ready  = 1'b1;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= cfol_pkg::GAIN_RST;
      coef_fb_r <= cfol_pkg::COEF_A_RST;
      coef_in_r <= cfol_pkg::COEF_B_RST;
      stages_r  <= cfol_pkg::ORDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfol_pkg::cfg_reg_t'(cfg_index))
        cfol_pkg::REG_GAIN:    gain_r    <= cfg_data[cfol_pkg::GAIN_W-1:0];
        cfol_pkg::REG_COEF_FB: coef_fb_r <= cfg_data[cfol_pkg::COEF_A_W-1:0];
        cfol_pkg::REG_COEF_IN: coef_in_r <= cfg_data[cfol_pkg::COEF_B_W-1:0];
        cfol_pkg::REG_STAGES:  stages_r  <= cfg_data[cfol_pkg::ORDER_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(stages_r) > STAGE_SLOTS - 1) begin
      order_nxt = IDX_W'(STAGE_SLOTS - 1);
    end else begin
      order_nxt = IDX_W'(stages_r);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cfol_pkg::ST_IDLE:      if (in_xfer) state_nxt = cfol_pkg::ST_SCALE_MUL;
      cfol_pkg::ST_SCALE_MUL: state_nxt = cfol_pkg::ST_SCALE_RND;
      cfol_pkg::ST_SCALE_RND: begin
        state_nxt = (order_r == '0) ? cfol_pkg::ST_FINISH : cfol_pkg::ST_STG_MUL;
      end
      cfol_pkg::ST_STG_MUL:   state_nxt = cfol_pkg::ST_STG_ADD;
      cfol_pkg::ST_STG_ADD: begin
        state_nxt = (idx_r == order_r) ? cfol_pkg::ST_FINISH : cfol_pkg::ST_STG_MUL;
      end
      cfol_pkg::ST_FINISH:    if (out_free) state_nxt = cfol_pkg::ST_IDLE;
      default:                state_nxt = cfol_pkg::ST_IDLE;
    endcase
  end

  // state outputs: memory ports, handshake, output load
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    wr_en     = 1'b0;
    wr_addr   = '0;
    wr_data   = cur_r;
    load_out  = 1'b0;
    unique case (state_r)
      cfol_pkg::ST_IDLE:      in_tready = 1'b1;
      cfol_pkg::ST_SCALE_MUL: rd_en = 1'b1;
      cfol_pkg::ST_SCALE_RND: begin
        rd_en   = (order_r != '0);
        rd_addr = IDX_W'(1);
      end
      cfol_pkg::ST_STG_MUL: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - IDX_W'(1);
        rd_en   = (idx_r != order_r);
        rd_addr = idx_r + IDX_W'(1);
      end
      cfol_pkg::ST_STG_ADD: ;
      cfol_pkg::ST_FINISH: begin
        wr_en    = out_free;
        wr_addr  = order_r;
        load_out = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // stage history memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (in_xfer && in_tuser) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign hist_q    = rd_vld_r ? $signed(rd_data_r) : '0;
  assign coef_in_s = $signed({1'b0, coef_in_r});
  assign sum_s     = 33'(cur_r) + 33'(prev_r);
  assign sc_sh     = (prod_r + 49'sd32768) >>> 16;
  assign p1_sh     = (p1_r + 64'sd536870912) >>> 30;
  assign p2_sh     = (p2_r + 65'sd536870912) >>> 30;
  assign acc       = 36'(p1_sh) + 36'(p2_sh);

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      cfol_pkg::ST_IDLE: begin
        if (in_xfer) begin
          sample_r <= $signed(in_tdata);
          order_r  <= order_nxt;
        end
      end
      cfol_pkg::ST_SCALE_MUL: prod_r <= sample_r * $signed({1'b0, gain_r});
      cfol_pkg::ST_SCALE_RND: begin
        cur_r  <= cfol_pkg::sat_hist(36'(sc_sh));
        prev_r <= hist_q;
        idx_r  <= IDX_W'(1);
      end
      cfol_pkg::ST_STG_MUL: begin
        p1_r   <= coef_fb_r * hist_q;
        p2_r   <= coef_in_s * sum_s;
        prev_r <= hist_q;
      end
      cfol_pkg::ST_STG_ADD: begin
        cur_r <= cfol_pkg::sat_hist(acc);
        idx_r <= idx_r + IDX_W'(1);
      end
      cfol_pkg::ST_FINISH: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= cfol_pkg::sat_sample(cur_r);
    end
  end

  `CFOL_ASSERT(a_stage_idx, (state_r == cfol_pkg::ST_STG_MUL || state_r == cfol_pkg::ST_STG_ADD) |-> (idx_r != '0 && idx_r <= order_r), "stage index out of range")
  `CFOL_ASSERT(a_rw_apart, (wr_en && rd_en) |-> (wr_addr != rd_addr), "read and write hit one entry")
  `CFOL_ASSERT(a_restart_clr, (in_xfer && in_tuser) |=> (vld_r == '0), "restart left history valid")
  `CFOL_ASSERT(a_one_item, in_xfer |=> !in_tready, "second item taken while busy")
  `CFOL_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> (!out_tvalid && state_r == cfol_pkg::ST_IDLE), "not idle after reset")

endmodule
